// File: rtl/core/wwm_pkg.sv
// ============================================================================
// wwm_pkg
// Shared widths, constants and the command format passed from the front end
// through the queue to the solver.
// ============================================================================
package wwm_pkg;

  localparam int MAX_WORDS   = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int LEN_W       = 8;
  localparam int COST_W      = 23;
  localparam int OUT_COST_W  = 22;
  localparam int SLACK_W     = 16;
  localparam int SQ_W        = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [COST_W-1:0]     COST_INF     = {COST_W{1'b1}};
  localparam logic [OUT_COST_W-1:0] COST_OUT_MAX = {OUT_COST_W{1'b1}};
  localparam logic [CNT_W-1:0]      MAX_COUNT    = CNT_W'(MAX_WORDS);
  localparam logic [LEN_W-1:0]      WIDTH_RESET  = 8'd80;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic             store;
    logic             last;
    logic             ovf;
    logic [CNT_W-1:0] n;
  } cmd_t;

endpackage

// File: rtl/core/word_wrap_min_square_slack_top.sv
// ============================================================================
// word_wrap_min_square_slack_top
// Word wrap by minimum summed squared slack over all lines.
// ============================================================================
// Words are taken one per cycle while busy is low and pass through a
// four-entry request queue to the solver; busy rises while the queue is full,
// as it can be while the solver is still working on the previous paragraph.
// After the last word the solver makes one pass per start word through the
// cost and length stores. Lines then come out one at a time, each for one
// cycle on result_valid; results cannot be held off, so the receiver must
// take every strobe. Words past 64 are dropped and reported on overflowed.
// line_width resets to 80.
module word_wrap_min_square_slack_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [wwm_pkg::LEN_W-1:0]       word_length,
  input  logic                            last_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wwm_pkg::LEN_W-1:0]       cfg_data,
  output logic                            result_valid,
  output logic [wwm_pkg::IDX_W-1:0]       line_start,
  output logic [wwm_pkg::CNT_W-1:0]       line_end,
  output logic                            last_line,
  output logic [wwm_pkg::OUT_COST_W-1:0]  total_cost,
  output logic                            infeasible,
  output logic                            overflowed
);

  wwm_pkg::cmd_t              push_cmd;
  wwm_pkg::cmd_t              head;
  logic                       push;
  logic                       full;
  logic                       empty;
  logic                       pop;
  logic [wwm_pkg::LEN_W-1:0]  line_width;

  wwm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .queue_full  (full),
    .word_length (word_length),
    .last_word   (last_word),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cfg_ready   (cfg_ready),
    .busy        (busy),
    .push        (push),
    .cmd         (push_cmd),
    .line_width  (line_width)
  );

  wwm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  wwm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (empty),
    .q_head       (head),
    .q_pop        (pop),
    .line_width   (line_width),
    .result_valid (result_valid),
    .line_start   (line_start),
    .line_end     (line_end),
    .last_line    (last_line),
    .total_cost   (total_cost),
    .infeasible   (infeasible),
    .overflowed   (overflowed)
  );

endmodule

// File: rtl/core/wwm_front.sv
// ============================================================================
// wwm_front
// Holds the width register, counts incoming words, decides whether each word
// is stored or dropped and builds the command for the solver queue.
// ============================================================================
module wwm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       queue_full,
  input  logic [wwm_pkg::LEN_W-1:0]  word_length,
  input  logic                       last_word,
  input  logic                       cfg_valid,
  input  logic [wwm_pkg::LEN_W-1:0]  cfg_data,
  output logic                       cfg_ready,
  output logic                       busy,
  output logic                       push,
  output wwm_pkg::cmd_t              cmd,
  output logic [wwm_pkg::LEN_W-1:0]  line_width
);

  logic [wwm_pkg::CNT_W-1:0] word_count;
  logic                      overflow_seen;
  logic                      fits;

  assign cfg_ready = 1'b1;
  assign busy      = queue_full;
  assign push      = start && !busy;
  assign fits      = word_count < wwm_pkg::MAX_COUNT;

  always_comb begin
    cmd.len   = word_length;
    cmd.idx   = word_count[wwm_pkg::IDX_W-1:0];
    cmd.store = fits;
    cmd.last  = last_word;
    cmd.ovf   = overflow_seen || !fits;
    cmd.n     = fits ? word_count + 7'd1 : word_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= wwm_pkg::WIDTH_RESET;
      word_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_width <= cfg_data;
      end
      if (push) begin
        if (last_word) begin
          word_count    <= '0;
          overflow_seen <= 1'b0;
        end else if (fits) begin
          word_count <= word_count + 7'd1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/wwm_queue.sv
// ============================================================================
// wwm_queue
// Short command FIFO between the front end and the solver.
// ============================================================================
module wwm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wwm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output wwm_pkg::cmd_t head
);

  wwm_pkg::cmd_t                slots [wwm_pkg::QUEUE_DEPTH];
  logic [wwm_pkg::QPTR_W-1:0]   wr_ptr;
  logic [wwm_pkg::QPTR_W-1:0]   rd_ptr;
  logic [wwm_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign full    = count == wwm_pkg::QCNT_W'(wwm_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/wwm_back.sv
// ============================================================================
// wwm_back
// Solver: stores word lengths, runs the backward cost recurrence one row per
// start word through a three-stage slack/square/compare pipeline, then walks
// the chosen breaks and strobes one result per line.
// ============================================================================
module wwm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  wwm_pkg::cmd_t                   q_head,
  output logic                            q_pop,
  input  logic [wwm_pkg::LEN_W-1:0]       line_width,
  output logic                            result_valid,
  output logic [wwm_pkg::IDX_W-1:0]       line_start,
  output logic [wwm_pkg::CNT_W-1:0]       line_end,
  output logic                            last_line,
  output logic [wwm_pkg::OUT_COST_W-1:0]  total_cost,
  output logic                            infeasible,
  output logic                            overflowed
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ISSUE    = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_WRITE    = 3'd3;
  localparam logic [2:0] ST_EMIT_RD  = 3'd4;
  localparam logic [2:0] ST_EMIT_OUT = 3'd5;

  logic [wwm_pkg::LEN_W-1:0]  len_mem  [wwm_pkg::MAX_WORDS];
  logic [wwm_pkg::COST_W-1:0] cost_mem [wwm_pkg::MAX_WORDS];
  logic [wwm_pkg::CNT_W-1:0]  brk_mem  [wwm_pkg::MAX_WORDS];

  logic [2:0]                  state;
  logic [wwm_pkg::CNT_W-1:0]   n;
  logic                        ovf;
  logic [wwm_pkg::IDX_W-1:0]   i;
  logic [wwm_pkg::IDX_W-1:0]   j;
  logic [wwm_pkg::CNT_W-1:0]   pos;
  logic [wwm_pkg::CNT_W-1:0]   n_m1;
  logic [wwm_pkg::IDX_W-1:0]   i_m1;
  logic [wwm_pkg::CNT_W-1:0]   j_p1;
  logic                        issue_v;
  logic                        issue_last;

  logic [wwm_pkg::LEN_W-1:0]   len_q;
  logic [wwm_pkg::COST_W-1:0]  cost_q;
  logic [wwm_pkg::CNT_W-1:0]   brk_q;

  logic                        p1_v, p1_first, p1_last;
  logic [wwm_pkg::IDX_W-1:0]   p1_j;
  logic signed [wwm_pkg::SLACK_W-1:0] slack;
  logic signed [wwm_pkg::SLACK_W-1:0] slack_next;

  logic                        p2_v, p2_last;
  logic [wwm_pkg::IDX_W-1:0]   p2_j;
  logic signed [wwm_pkg::SLACK_W-1:0] p2_slack;
  logic [wwm_pkg::COST_W-1:0]  p2_cost;

  logic                        p3_v, p3_last;
  logic [wwm_pkg::IDX_W-1:0]   p3_j;
  logic [wwm_pkg::COST_W-1:0]  p3_row;
  logic [wwm_pkg::COST_W-1:0]  p3_cost;

  logic [wwm_pkg::SQ_W-1:0]    square;
  logic [wwm_pkg::COST_W-1:0]  row_cost;
  logic [wwm_pkg::COST_W:0]    sum;
  logic [wwm_pkg::COST_W-1:0]  cand;
  logic [wwm_pkg::CNT_W-1:0]   cand_brk;
  logic                        take;

  logic [wwm_pkg::COST_W-1:0]  best;
  logic [wwm_pkg::CNT_W-1:0]   brk;
  logic                        have;

  assign n_m1       = q_head.n - 7'd1;
  assign i_m1       = i - 6'd1;
  assign j_p1       = {1'b0, j} + 7'd1;
  assign issue_v    = state == ST_ISSUE;
  assign issue_last = j_p1 == n;
  assign q_pop      = (state == ST_IDLE) && !q_empty;

  // length store
  always_ff @(posedge clk) begin
    if (q_pop && q_head.store) begin
      len_mem[q_head.idx] <= q_head.len;
    end
    len_q <= len_mem[j];
  end

  // cost and break stores
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      cost_mem[i] <= best;
      brk_mem[i]  <= brk;
    end
    cost_q <= cost_mem[j_p1[wwm_pkg::IDX_W-1:0]];
    brk_q  <= brk_mem[pos[wwm_pkg::IDX_W-1:0]];
  end

  // stage 1: running slack
  always_comb begin
    if (p1_first) begin
      slack_next = $signed({8'd0, line_width}) - $signed({8'd0, len_q});
    end else begin
      slack_next = slack - $signed({8'd0, len_q}) - 16'sd1;
    end
  end

  // stage 2: squared slack
  assign square   = p2_slack[7:0] * p2_slack[7:0];
  assign row_cost = (p2_slack < 0) ? wwm_pkg::COST_INF : {7'd0, square};

  // stage 3: candidate and compare
  always_comb begin
    sum = {1'b0, p3_cost} + {1'b0, p3_row};
    if (p3_last) begin
      cand     = p3_row;
      cand_brk = n;
    end else begin
      if (p3_cost >= wwm_pkg::COST_INF || p3_row >= wwm_pkg::COST_INF ||
          sum >= {1'b0, wwm_pkg::COST_INF}) begin
        cand = wwm_pkg::COST_INF;
      end else begin
        cand = sum[wwm_pkg::COST_W-1:0];
      end
      cand_brk = {1'b0, p3_j} + 7'd1;
    end
    // ascending scan, ties go to the later break
    take = p3_v && (!have || cand <= best);
  end

  always_ff @(posedge clk) begin
    p1_j     <= j;
    p1_first <= j == i;
    p1_last  <= issue_last;
    if (p1_v) begin
      slack <= slack_next;
    end
    p2_j     <= p1_j;
    p2_last  <= p1_last;
    p2_slack <= slack_next;
    p2_cost  <= cost_q;
    p3_j     <= p2_j;
    p3_last  <= p2_last;
    p3_row   <= row_cost;
    p3_cost  <= p2_cost;
    if (take) begin
      best <= cand;
      brk  <= cand_brk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      p1_v         <= 1'b0;
      p2_v         <= 1'b0;
      p3_v         <= 1'b0;
      have         <= 1'b0;
      result_valid <= 1'b0;
      n            <= '0;
      ovf          <= 1'b0;
      i            <= '0;
      j            <= '0;
      pos          <= '0;
    end else begin
      p1_v         <= issue_v;
      p2_v         <= p1_v;
      p3_v         <= p2_v;
      result_valid <= 1'b0;
      if (take) begin
        have <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_head.last) begin
            n     <= q_head.n;
            ovf   <= q_head.ovf;
            i     <= n_m1[wwm_pkg::IDX_W-1:0];
            j     <= n_m1[wwm_pkg::IDX_W-1:0];
            have  <= 1'b0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (issue_last) begin
            state <= ST_DRAIN;
          end else begin
            j <= j_p1[wwm_pkg::IDX_W-1:0];
          end
        end
        ST_DRAIN: begin
          if (p3_v && p3_last) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          have <= 1'b0;
          if (i == '0) begin
            infeasible <= best >= wwm_pkg::COST_INF;
            total_cost <= (best >= wwm_pkg::COST_INF) ? wwm_pkg::COST_OUT_MAX
                                                      : best[wwm_pkg::OUT_COST_W-1:0];
            pos        <= '0;
            state      <= ST_EMIT_RD;
          end else begin
            i     <= i_m1;
            j     <= i_m1;
            state <= ST_ISSUE;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          result_valid <= 1'b1;
          line_start   <= pos[wwm_pkg::IDX_W-1:0];
          line_end     <= brk_q;
          last_line    <= brk_q >= n;
          overflowed   <= ovf;
          if (brk_q >= n || brk_q <= pos) begin
            state <= ST_IDLE;
          end else begin
            pos   <= brk_q;
            state <= ST_EMIT_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: bench/tb_word_wrap_min_square_slack_top.sv
// ============================================================================
// tb_word_wrap_min_square_slack_top
// Self-checking bench for the minimum squared slack word wrap block.
// ============================================================================
// Paragraphs are sent one word per request and a local line-break planner
// predicts every output line. Each strobed line is checked field by field
// against the oldest predicted line. The width register is rewritten between
// paragraphs once the block has drained.
module tb_word_wrap_min_square_slack_top;

  typedef struct {
    logic [wwm_pkg::IDX_W-1:0]      first;
    logic [wwm_pkg::CNT_W-1:0]      stop;
    logic                           final_line;
    logic [wwm_pkg::OUT_COST_W-1:0] cost;
    logic                           no_fit;
    logic                           dropped;
  } wrap_line_t;

  localparam int unsigned SAT_COST = int'(wwm_pkg::COST_INF);
  localparam int SETTLE = 12;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [wwm_pkg::LEN_W-1:0]      word_length;
  logic                           last_word;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [wwm_pkg::LEN_W-1:0]      cfg_data;
  logic                           result_valid;
  logic [wwm_pkg::IDX_W-1:0]      line_start;
  logic [wwm_pkg::CNT_W-1:0]      line_end;
  logic                           last_line;
  logic [wwm_pkg::OUT_COST_W-1:0] total_cost;
  logic                           infeasible;
  logic                           overflowed;

  wrap_line_t                pending_lines[$];
  wrap_line_t                want_line;
  logic [wwm_pkg::LEN_W-1:0] para_len[wwm_pkg::MAX_WORDS];
  int                        para_count;
  bit                        para_ovf;
  logic [wwm_pkg::LEN_W-1:0] width_cfg;
  int                        words_sent;
  bit                        quiet;
  bit                        failed;

  word_wrap_min_square_slack_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .word_length  (word_length),
    .last_word    (last_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .line_start   (line_start),
    .line_end     (line_end),
    .last_line    (last_line),
    .total_cost   (total_cost),
    .infeasible   (infeasible),
    .overflowed   (overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Store one word; on the last word solve the breaks and queue every line.
  function automatic void break_paragraph(input logic [wwm_pkg::LEN_W-1:0] len,
                                          input logic lw);
    int unsigned cost[wwm_pkg::MAX_WORDS];
    int unsigned row[wwm_pkg::MAX_WORDS];
    int          brk[wwm_pkg::MAX_WORDS];
    int unsigned cand;
    int unsigned total;
    int          n;
    int          pos;
    int          slack;
    bit          bad;
    wrap_line_t  ln;
    if (para_count < wwm_pkg::MAX_WORDS) begin
      para_len[para_count] = len;
      para_count++;
    end else begin
      para_ovf = 1'b1;
    end
    if (!lw) return;
    n = para_count;
    for (int i = n - 1; i >= 0; i--) begin
      slack = int'(width_cfg) - int'(para_len[i]);
      for (int j = i; j < n; j++) begin
        if (j > i) slack -= int'(para_len[j]) + 1;
        row[j] = (slack < 0) ? SAT_COST : int'(slack * slack);
      end
      cost[i] = row[n-1];
      brk[i] = n;
      // scan high to low, only a strictly lower cost wins
      for (int j = n - 1; j > i; j--) begin
        if (row[j-1] >= SAT_COST || cost[j] >= SAT_COST) continue;
        cand = cost[j] + row[j-1];
        if (cand >= SAT_COST) cand = SAT_COST;
        if (cand < cost[i]) begin
          cost[i] = cand;
          brk[i] = j;
        end
      end
    end
    bad = (cost[0] >= SAT_COST);
    total = bad ? int'(wwm_pkg::COST_OUT_MAX) : (cost[0] & int'(wwm_pkg::COST_OUT_MAX));
    pos = 0;
    while (pos < n) begin
      ln.first      = wwm_pkg::IDX_W'(pos);
      ln.stop       = wwm_pkg::CNT_W'(brk[pos]);
      ln.final_line = (brk[pos] >= n);
      ln.cost       = wwm_pkg::OUT_COST_W'(total);
      ln.no_fit     = bad;
      ln.dropped    = para_ovf;
      pending_lines.insert(pending_lines.size(), ln);
      pos = brk[pos];
    end
    para_count = 0;
    para_ovf = 1'b0;
  endfunction

  function automatic logic [wwm_pkg::LEN_W-1:0] random_length();
    int cap;
    cap = (width_cfg > 3) ? int'(width_cfg) / 3 : 1;
    if ($urandom_range(99) < 12) return wwm_pkg::LEN_W'($urandom_range(0, 255));
    return wwm_pkg::LEN_W'($urandom_range(1, cap));
  endfunction

  task automatic send_word(input logic [wwm_pkg::LEN_W-1:0] len, input logic lw);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 35) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    word_length <= len;
    last_word <= lw;
    do @(posedge clk); while (busy);
    break_paragraph(len, lw);
    words_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_lines.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_width(input logic [wwm_pkg::LEN_W-1:0] w);
    wait_idle();
    if (!quiet) repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_cfg = w;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_lines.size() == 0) begin
        $error("unexpected line %0d..%0d", line_start, line_end);
        failed = 1'b1;
      end else begin
        want_line = pending_lines.pop_front();
        check_field("line_start", want_line.first, line_start);
        check_field("line_end", want_line.stop, line_end);
        check_field("last_line", want_line.final_line, last_line);
        check_field("total_cost", want_line.cost, total_cost);
        check_field("infeasible", want_line.no_fit, infeasible);
        check_field("overflowed", want_line.dropped, overflowed);
      end
    end
  end

  // width still at its reset value here
  task automatic test_reset_width();
    send_word(8'd30, 1'b0);
    send_word(8'd25, 1'b0);
    send_word(8'd20, 1'b0);
    send_word(8'd10, 1'b0);
    send_word(8'd1, 1'b1);
  endtask

  task automatic test_single_words();
    write_width(8'd80);
    send_word(8'd80, 1'b1);
    send_word(8'd255, 1'b1);
  endtask

  task automatic test_width_extremes();
    write_width(8'd255);
    send_word(8'd255, 1'b1);
    send_word(8'd127, 1'b0);
    send_word(8'd127, 1'b1);
    write_width(8'd1);
    send_word(8'd1, 1'b0);
    send_word(8'd1, 1'b0);
    send_word(8'd1, 1'b1);
    send_word(8'd1, 1'b0);
    send_word(8'd2, 1'b1);
  endtask

  task automatic test_zero_values();
    write_width(8'd0);
    send_word(8'd0, 1'b1);
    send_word(8'd0, 1'b0);
    send_word(8'd0, 1'b1);
  endtask

  // an over-long word in the middle makes every break set infeasible
  task automatic test_infeasible_middle();
    write_width(8'd20);
    send_word(8'd5, 1'b0);
    send_word(8'd30, 1'b0);
    send_word(8'd5, 1'b1);
  endtask

  // full store, then a paragraph whose tail is dropped, last word included
  task automatic test_capacity();
    int extra;
    quiet = 1'b1;
    write_width(8'd255);
    for (int k = 1; k <= wwm_pkg::MAX_WORDS; k++) begin
      send_word(wwm_pkg::LEN_W'($urandom_range(1, 4)), k == wwm_pkg::MAX_WORDS);
    end
    extra = wwm_pkg::MAX_WORDS + $urandom_range(1, 4);
    for (int k = 1; k <= extra; k++) begin
      send_word(wwm_pkg::LEN_W'($urandom_range(1, 6)), k == extra);
    end
    wait_idle();
    quiet = 1'b0;
  endtask

  task automatic test_random_paragraphs();
    int target;
    int n;
    target = words_sent + 150;
    while (words_sent < target) begin
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(4) == 0) write_width(wwm_pkg::LEN_W'($urandom_range(1, 255)));
        else write_width(wwm_pkg::LEN_W'($urandom_range(20, 120)));
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 1; k <= n; k++) send_word(random_length(), k == n);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    word_length = '0;
    last_word = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    width_cfg = wwm_pkg::WIDTH_RESET;
    para_count = 0;
    para_ovf = 1'b0;
    words_sent = 0;
    quiet = 1'b0;
    failed = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_width();
    test_single_words();
    test_width_extremes();
    test_zero_values();
    test_infeasible_middle();
    test_capacity();
    test_random_paragraphs();
    wait_idle();
    repeat (20) @(posedge clk);
    if (failed) begin
      $display("[word_wrap_min_square_slack_top] ERROR");
    end else begin
      $display("[word_wrap_min_square_slack_top] OK");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("[word_wrap_min_square_slack_top] ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/wwm_pkg.sv
rtl/core/wwm_front.sv
rtl/core/wwm_queue.sv
rtl/core/wwm_back.sv
rtl/core/word_wrap_min_square_slack_top.sv
bench/tb_word_wrap_min_square_slack_top.sv
